// File: hdl/mmht_pkg.sv
`timescale 1ns / 1ps
// Package: types, constants and codes used by the min-merge hash table core.
package mmht_pkg;

    localparam int LOG_CAPACITY_DEF = 10;

    localparam logic [63:0] MIX_ADD_0 = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MUL_0 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL_1 = 64'h94d049bb133111eb;

    localparam logic [7:0] EMPTY_VALUE = 8'd255;
    localparam logic [7:0] MAX_VALUE   = 8'd254;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [2:0] ST_NEW     = 3'd0;
    localparam logic [2:0] ST_LOWERED = 3'd1;
    localparam logic [2:0] ST_KEPT    = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_READ    = 3'd4;
    localparam logic [2:0] ST_CLEARED = 3'd5;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH0,
        S_MUL,
        S_HASH1A,
        S_HASH1B,
        S_HASH2,
        S_PROBE_RD,
        S_PROBE_CHK,
        S_READ_RD,
        S_READ_CHK,
        S_EMIT
    } mmht_state_t;

endpackage

// File: hdl/mmht_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with a registered read.
module mmht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/min_merge_hash_table_core.sv
`timescale 1ns / 1ps
// Top level of the min-merge hash table: hash sequencer, probe engine and slot memories.
//
//  channel | beat direction | handshake            | payload
//  --------+----------------+----------------------+------------------------------------------
//  in      | into block     | in_valid / in_stall  | opcode, key_low, key_high, new_value,
//          |                |                      | slot_index
//  out     | out of block   | out_valid / out_stall| status, slot_found, occupied, entry_key_low,
//          |                |                      | entry_key_high, entry_value, entry_count
//
// One beat is worked on at a time. An insert first hashes the key (two 64-bit products,
// each built from three 32 by 32 partial products on one shared multiplier) and then probes
// slot by slot, each probe waiting in a read state for the registered read of the slot
// memories before its check state. A read also has a read and a check state, and a clear
// sweeps the value memory. After reset the same sweep runs once before the first beat is taken.
// A finished result sits in the output register, so the next beat may enter while it waits;
// the following result then holds until out_stall is released.
module min_merge_hash_table_core
    import mmht_pkg::*;
#(
    parameter int LOG_CAPACITY = LOG_CAPACITY_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [63:0] key_low,
    input  logic [63:0] key_high,
    input  logic [7:0]  new_value,
    input  logic [9:0]  slot_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [9:0]  slot_found,
    output logic        occupied,
    output logic [63:0] entry_key_low,
    output logic [63:0] entry_key_high,
    output logic [7:0]  entry_value,
    output logic [10:0] entry_count
);

    localparam int AW    = LOG_CAPACITY;
    localparam int CW    = LOG_CAPACITY + 1;
    localparam int DEPTH = 1 << LOG_CAPACITY;

    // Control state.
    mmht_state_t state_reg, state_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [AW-1:0] probe_reg, probe_next;
    logic [CW-1:0] count_reg, count_next;
    logic          clr_op_reg, clr_op_next;
    logic          mul_sel_reg, mul_sel_next;
    logic [1:0]    mstep_reg, mstep_next;
    logic          out_valid_reg, out_valid_next;

    // Payload held for the beat in progress.
    logic [63:0] klo_reg, klo_next;
    logic [63:0] khi_reg, khi_next;
    logic [7:0]  val_reg, val_next;
    logic [63:0] hx_reg, hx_next;
    logic [63:0] tmp_reg, tmp_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] prod_reg, prod_next;

    // Result waiting to move into the output register.
    logic [2:0]  rs_status_reg, rs_status_next;
    logic [AW-1:0] rs_slot_reg, rs_slot_next;
    logic        rs_occ_reg, rs_occ_next;
    logic [63:0] rs_klo_reg, rs_klo_next;
    logic [63:0] rs_khi_reg, rs_khi_next;
    logic [7:0]  rs_val_reg, rs_val_next;

    logic [2:0]  o_status_reg, o_status_next;
    logic [9:0]  o_slot_reg, o_slot_next;
    logic        o_occ_reg, o_occ_next;
    logic [63:0] o_klo_reg, o_klo_next;
    logic [63:0] o_khi_reg, o_khi_next;
    logic [7:0]  o_val_reg, o_val_next;
    logic [10:0] o_count_reg, o_count_next;

    // Memory ports.
    logic          key_wr_en;
    logic [127:0]  key_wr_data;
    logic [127:0]  key_rd_data;
    logic          val_wr_en;
    logic [AW-1:0] val_wr_addr;
    logic [7:0]    val_wr_data;
    logic [7:0]    val_rd_data;
    logic          rd_en;

    // Helpers.
    logic [31:0]   mul_a, mul_b;
    logic [63:0]   mul_k;
    logic [63:0]   mix_t, mix_z, mix_h;
    logic [63:0]   acc_term;
    logic          key_match;
    logic [AW+9:0] idx_ext;
    logic [AW+9:0] slot_ext;
    logic [CW+10:0] count_ext;
    logic          accept;

    mmht_ram #(.WIDTH(128), .DEPTH(DEPTH)) u_key_ram (
        .clk     (clk),
        .wr_en   (key_wr_en),
        .wr_addr (addr_reg),
        .wr_data (key_wr_data),
        .rd_en   (rd_en),
        .rd_addr (addr_reg),
        .rd_data (key_rd_data)
    );

    mmht_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_val_ram (
        .clk     (clk),
        .wr_en   (val_wr_en),
        .wr_addr (val_wr_addr),
        .wr_data (val_wr_data),
        .rd_en   (rd_en),
        .rd_addr (addr_reg),
        .rd_data (val_rd_data)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    // The slot index wraps to the table size; the zero-extended copy covers tables
    // both smaller and larger than the ten-bit index.
    assign idx_ext   = {{AW{1'b0}}, slot_index};
    assign slot_ext  = {10'd0, rs_slot_reg};
    assign count_ext = {11'd0, count_reg};

    // Multiplier operand selection: the low 64 bits of x*K are built from
    // xl*kl + ((xh*kl + xl*kh) << 32), one partial product per cycle.
    assign mul_k = mul_sel_reg ? MIX_MUL_1 : MIX_MUL_0;
    always_comb
    begin
        unique case (mstep_reg)
            2'd0:    begin mul_a = hx_reg[31:0];  mul_b = mul_k[31:0];  end
            2'd1:    begin mul_a = hx_reg[63:32]; mul_b = mul_k[31:0];  end
            default: begin mul_a = hx_reg[31:0];  mul_b = mul_k[63:32]; end
        endcase
    end
    assign acc_term = (mstep_reg == 2'd1) ? prod_reg : {prod_reg[31:0], 32'd0};

    assign mix_t = klo_reg + MIX_ADD_0;
    assign mix_z = hx_reg ^ (tmp_reg + (hx_reg >> 2));
    assign mix_h = acc_reg ^ (acc_reg >> 31);

    assign key_match = (key_rd_data == {khi_reg, klo_reg});

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        probe_next     = probe_reg;
        count_next     = count_reg;
        clr_op_next    = clr_op_reg;
        mul_sel_next   = mul_sel_reg;
        mstep_next     = mstep_reg;
        klo_next       = klo_reg;
        khi_next       = khi_reg;
        val_next       = val_reg;
        hx_next        = hx_reg;
        tmp_next       = tmp_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        rs_status_next = rs_status_reg;
        rs_slot_next   = rs_slot_reg;
        rs_occ_next    = rs_occ_reg;
        rs_klo_next    = rs_klo_reg;
        rs_khi_next    = rs_khi_reg;
        rs_val_next    = rs_val_reg;
        o_status_next  = o_status_reg;
        o_slot_next    = o_slot_reg;
        o_occ_next     = o_occ_reg;
        o_klo_next     = o_klo_reg;
        o_khi_next     = o_khi_reg;
        o_val_next     = o_val_reg;
        o_count_next   = o_count_reg;
        out_valid_next = out_valid_reg && out_stall;
        key_wr_en      = 1'b0;
        key_wr_data    = {khi_reg, klo_reg};
        val_wr_en      = 1'b0;
        val_wr_addr    = addr_reg;
        val_wr_data    = val_reg;
        rd_en          = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                // Sweep the value memory back to empty, one slot a cycle.
                val_wr_en   = 1'b1;
                val_wr_data = EMPTY_VALUE;
                addr_next   = addr_reg + 1'b1;
                count_next  = '0;
                if (addr_reg == {AW{1'b1}})
                begin
                    if (clr_op_reg)
                    begin
                        rs_status_next = ST_CLEARED;
                        rs_slot_next   = '0;
                        rs_occ_next    = 1'b0;
                        rs_klo_next    = '0;
                        rs_khi_next    = '0;
                        rs_val_next    = '0;
                        state_next     = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    klo_next = key_low;
                    khi_next = key_high;
                    val_next = (new_value == EMPTY_VALUE) ? MAX_VALUE : new_value;
                    priority case (opcode)
                        OP_INSERT:
                        begin
                            state_next = S_HASH0;
                        end
                        OP_READ:
                        begin
                            addr_next  = idx_ext[AW-1:0];
                            state_next = S_READ_RD;
                        end
                        OP_CLEAR:
                        begin
                            addr_next   = '0;
                            clr_op_next = 1'b1;
                            state_next  = S_CLEAR;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_HASH0:
            begin
                hx_next      = mix_t ^ (mix_t >> 30);
                mul_sel_next = 1'b0;
                mstep_next   = 2'd0;
                state_next   = S_MUL;
            end
            S_MUL:
            begin
                // Partial product in step 0..2, accumulation one step behind.
                prod_next  = mul_a * mul_b;
                mstep_next = mstep_reg + 2'd1;
                if (mstep_reg == 2'd0)
                begin
                    acc_next = '0;
                end
                else
                begin
                    acc_next = acc_reg + acc_term;
                end
                if (mstep_reg == 2'd3)
                begin
                    state_next = mul_sel_reg ? S_HASH2 : S_HASH1A;
                end
            end
            S_HASH1A:
            begin
                hx_next    = acc_reg;
                tmp_next   = khi_reg + MIX_MUL_1 + (acc_reg << 6);
                state_next = S_HASH1B;
            end
            S_HASH1B:
            begin
                hx_next      = mix_z ^ (mix_z >> 27);
                mul_sel_next = 1'b1;
                mstep_next   = 2'd0;
                state_next   = S_MUL;
            end
            S_HASH2:
            begin
                addr_next  = mix_h[AW-1:0];
                probe_next = '0;
                state_next = S_PROBE_RD;
            end
            S_PROBE_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_PROBE_CHK;
            end
            S_PROBE_CHK:
            begin
                rs_slot_next = addr_reg;
                rs_occ_next  = 1'b1;
                rs_klo_next  = klo_reg;
                rs_khi_next  = khi_reg;
                if (val_rd_data == EMPTY_VALUE)
                begin
                    key_wr_en      = 1'b1;
                    val_wr_en      = 1'b1;
                    count_next     = count_reg + 1'b1;
                    rs_status_next = ST_NEW;
                    rs_val_next    = val_reg;
                    state_next     = S_EMIT;
                end
                else if (key_match)
                begin
                    if (val_reg < val_rd_data)
                    begin
                        val_wr_en      = 1'b1;
                        rs_status_next = ST_LOWERED;
                        rs_val_next    = val_reg;
                    end
                    else
                    begin
                        rs_status_next = ST_KEPT;
                        rs_val_next    = val_rd_data;
                    end
                    state_next = S_EMIT;
                end
                else if (probe_reg == {AW{1'b1}})
                begin
                    rs_status_next = ST_FULL;
                    rs_slot_next   = '0;
                    rs_occ_next    = 1'b0;
                    rs_klo_next    = '0;
                    rs_khi_next    = '0;
                    rs_val_next    = '0;
                    state_next     = S_EMIT;
                end
                else
                begin
                    addr_next  = addr_reg + 1'b1;
                    probe_next = probe_reg + 1'b1;
                    state_next = S_PROBE_RD;
                end
            end
            S_READ_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_READ_CHK;
            end
            S_READ_CHK:
            begin
                rs_status_next = ST_READ;
                rs_slot_next   = addr_reg;
                rs_occ_next    = (val_rd_data != EMPTY_VALUE);
                rs_klo_next    = rs_occ_next ? key_rd_data[63:0] : 64'd0;
                rs_khi_next    = rs_occ_next ? key_rd_data[127:64] : 64'd0;
                rs_val_next    = val_rd_data;
                state_next     = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    o_status_next  = rs_status_reg;
                    o_slot_next    = slot_ext[9:0];
                    o_occ_next     = rs_occ_reg;
                    o_klo_next     = rs_klo_reg;
                    o_khi_next     = rs_khi_reg;
                    o_val_next     = rs_val_reg;
                    o_count_next   = count_ext[10:0];
                    out_valid_next = 1'b1;
                    clr_op_next    = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            addr_reg      <= '0;
            probe_reg     <= '0;
            count_reg     <= '0;
            clr_op_reg    <= 1'b0;
            mul_sel_reg   <= 1'b0;
            mstep_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            probe_reg     <= probe_next;
            count_reg     <= count_next;
            clr_op_reg    <= clr_op_next;
            mul_sel_reg   <= mul_sel_next;
            mstep_reg     <= mstep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        klo_reg       <= klo_next;
        khi_reg       <= khi_next;
        val_reg       <= val_next;
        hx_reg        <= hx_next;
        tmp_reg       <= tmp_next;
        acc_reg       <= acc_next;
        prod_reg      <= prod_next;
        rs_status_reg <= rs_status_next;
        rs_slot_reg   <= rs_slot_next;
        rs_occ_reg    <= rs_occ_next;
        rs_klo_reg    <= rs_klo_next;
        rs_khi_reg    <= rs_khi_next;
        rs_val_reg    <= rs_val_next;
        o_status_reg  <= o_status_next;
        o_slot_reg    <= o_slot_next;
        o_occ_reg     <= o_occ_next;
        o_klo_reg     <= o_klo_next;
        o_khi_reg     <= o_khi_next;
        o_val_reg     <= o_val_next;
        o_count_reg   <= o_count_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = o_status_reg;
    assign slot_found     = o_slot_reg;
    assign occupied       = o_occ_reg;
    assign entry_key_low  = o_klo_reg;
    assign entry_key_high = o_khi_reg;
    assign entry_value    = o_val_reg;
    assign entry_count    = o_count_reg;

endmodule
